FILE: rtl/core/irg_pkg.sv
// Package: shared constants, types and microcode for the interpolated random generator.
`default_nettype none

package irg_pkg;

    // Default widths of sample values and of the phase accumulator
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int PHASE_BITS_DEF  = 32;

    // Fixed field widths
    localparam int RATE_W         = 24;
    localparam int RATE_FRAC_BITS = 8;      // rate is given in 1/256 Hz
    localparam int DRAW_W         = 16;
    localparam int SR_W           = 18;
    localparam int MAG_W          = RATE_W;
    localparam int LIMIT_W        = SR_W + RATE_FRAC_BITS;
    localparam int REM_W          = SR_W + 1;

    localparam logic [SR_W-1:0] SR_RESET = 18'd44100;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LEVEL = 2'd1;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_CLAMP,
        OP_DIV,
        OP_PHASE,
        OP_TARGET,
        OP_DIFF,
        OP_MUL,
        OP_EMIT
    } t_op;

    // Jump conditions
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_NO_INPUT,
        COND_DIV_MORE,
        COND_NO_WRAP,
        COND_OUT_BUSY
    } t_cond;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STEP_IDLE   = 4'd0;
    localparam t_step STEP_CLAMP  = 4'd1;
    localparam t_step STEP_DIV    = 4'd2;
    localparam t_step STEP_PHASE  = 4'd3;
    localparam t_step STEP_CHECK  = 4'd4;
    localparam t_step STEP_TARGET = 4'd5;
    localparam t_step STEP_DIFF   = 4'd6;
    localparam t_step STEP_MUL    = 4'd7;
    localparam t_step STEP_EMIT   = 4'd8;

    // Control word: op runs, then jump to target if cond is true.
    // hold suppresses the op while the jump is taken (wait loops).
    // last returns to idle when the jump is not taken.
    typedef struct packed {
        t_op   op;
        t_cond cond;
        logic  hold;
        logic  last;
        t_step target;
    } t_uword;

    // Status into the sequencer
    typedef struct packed {
        logic in_valid;
        logic div_more;
        logic wrap_up;
        logic out_busy;
    } t_flags;

    // Status out of the datapath
    typedef struct packed {
        logic div_more;
        logic wrap_up;
    } t_dp_status;

    // Sequencer outputs
    typedef struct packed {
        t_op  op;
        logic in_ready;
    } t_ctl;

    // Decoded configuration write
    typedef struct packed {
        logic                  rate_we;
        logic                  start_we;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // Microcode ROM
    function automatic t_uword irg_ucode(input t_step pc);
        t_uword w;
        case (pc)
            STEP_IDLE:   w = '{OP_LOAD,   COND_NO_INPUT, 1'b1, 1'b0, STEP_IDLE};
            STEP_CLAMP:  w = '{OP_CLAMP,  COND_NEVER,    1'b0, 1'b0, STEP_IDLE};
            STEP_DIV:    w = '{OP_DIV,    COND_DIV_MORE, 1'b0, 1'b0, STEP_DIV};
            STEP_PHASE:  w = '{OP_PHASE,  COND_NEVER,    1'b0, 1'b0, STEP_IDLE};
            STEP_CHECK:  w = '{OP_NOP,    COND_NO_WRAP,  1'b0, 1'b0, STEP_DIFF};
            STEP_TARGET: w = '{OP_TARGET, COND_NEVER,    1'b0, 1'b0, STEP_IDLE};
            STEP_DIFF:   w = '{OP_DIFF,   COND_NEVER,    1'b0, 1'b0, STEP_IDLE};
            STEP_MUL:    w = '{OP_MUL,    COND_NEVER,    1'b0, 1'b0, STEP_IDLE};
            STEP_EMIT:   w = '{OP_EMIT,   COND_OUT_BUSY, 1'b1, 1'b1, STEP_EMIT};
            default:     w = '{OP_NOP,    COND_NEVER,    1'b0, 1'b1, STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/irg_stream_ifs.sv
// Interfaces: sample input, result output and configuration write channels.
`default_nettype none

interface irg_sample_if #(
    parameter int SAMPLE_BITS = irg_pkg::SAMPLE_BITS_DEF
);
    import irg_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] min_level;
    logic signed [SAMPLE_BITS-1:0] max_level;
    logic signed [RATE_W-1:0]      rate_hz;
    logic        [DRAW_W-1:0]      random_draw;

    modport source (output valid, min_level, max_level, rate_hz, random_draw, input ready);
    modport sink   (input valid, min_level, max_level, rate_hz, random_draw, output ready);
endinterface

interface irg_result_if #(
    parameter int SAMPLE_BITS = irg_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] output_sample;
    logic                          new_target;

    modport source (output valid, output_sample, new_target, input ready);
    modport sink   (input valid, output_sample, new_target, output ready);
endinterface

interface irg_cfg_if;
    import irg_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/irg_sequencer.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
`default_nettype none

module irg_sequencer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  irg_pkg::t_flags i_flags,
    output irg_pkg::t_ctl   o_ctl
);
    import irg_pkg::*;

    t_step  r_pc;
    t_step  n_pc;
    t_uword w_uw;
    logic   w_jump;

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Control word decode and next step
    always_comb begin
        w_uw = irg_ucode(r_pc);
        case (w_uw.cond)
            COND_NEVER:    w_jump = 1'b0;
            COND_NO_INPUT: w_jump = !i_flags.in_valid;
            COND_DIV_MORE: w_jump = i_flags.div_more;
            COND_NO_WRAP:  w_jump = !i_flags.wrap_up;
            COND_OUT_BUSY: w_jump = i_flags.out_busy;
            default:       w_jump = 1'b0;
        endcase

        if (w_jump) begin
            n_pc = w_uw.target;
        end else if (w_uw.last) begin
            n_pc = STEP_IDLE;
        end else begin
            n_pc = r_pc + t_step'(1);
        end

        o_ctl.op       = (w_uw.hold && w_jump) ? OP_NOP : w_uw.op;
        o_ctl.in_ready = (r_pc == STEP_IDLE);
    end

endmodule

`default_nettype wire

FILE: rtl/core/irg_datapath.sv
// Datapath: serial phase-step divider, phase accumulator, target pick and interpolation.
`default_nettype none

module irg_datapath #(
    parameter int SAMPLE_BITS = irg_pkg::SAMPLE_BITS_DEF,
    parameter int PHASE_BITS  = irg_pkg::PHASE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  irg_pkg::t_op                       i_op,
    input  irg_pkg::t_cfg_wr                   i_cfg,
    input  logic signed [SAMPLE_BITS-1:0]      i_min_level,
    input  logic signed [SAMPLE_BITS-1:0]      i_max_level,
    input  logic signed [irg_pkg::RATE_W-1:0]  i_rate_hz,
    input  logic        [irg_pkg::DRAW_W-1:0]  i_random_draw,
    output irg_pkg::t_dp_status                o_status,
    output logic signed [SAMPLE_BITS-1:0]      o_sample,
    output logic                               o_new_target
);
    import irg_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int PB    = PHASE_BITS;
    localparam int FB    = (PB > 32) ? 32 : PB;
    localparam int CNT_W = $clog2(PB + 1);
    localparam int TP_W  = SB + 1 + DRAW_W + 1;
    localparam int MP_W  = SB + 1 + FB + 1;
    localparam int POS_W = PB + 2;
    localparam int VAL_W = SB + 3;

    // Configuration and persistent state
    logic        [SR_W-1:0]   r_sample_rate;
    logic signed [SB-1:0]     r_start_level;
    logic signed [SB-1:0]     r_held;
    logic signed [SB-1:0]     r_prev;
    logic signed [SB:0]       r_diff;
    logic        [PB-1:0]     r_phase;
    logic                     r_first;
    logic                     r_wrap_up;

    // Per-item working registers
    logic signed [SB-1:0]     r_mn;
    logic signed [SB:0]       r_range;
    logic        [DRAW_W-1:0] r_draw;
    logic                     r_neg;
    logic        [MAG_W-1:0]  r_mag;
    logic        [SR_W-1:0]   r_rem;
    logic        [PB-1:0]     r_dsh;
    logic        [PB-1:0]     r_quo;
    logic        [CNT_W-1:0]  r_cnt;
    logic signed [TP_W-1:0]   r_tprod;
    logic signed [MP_W-1:0]   r_mprod;

    logic        [SR_W-1:0]    w_sr_eff;
    logic        [LIMIT_W-1:0] w_limit;
    logic        [MAG_W-1:0]   w_rate_mag;
    logic        [MAG_W-1:0]   w_mag_clamp;
    logic        [REM_W-1:0]   w_trial;
    logic        [REM_W-1:0]   w_trial_sub;
    logic                      w_trial_ge;
    logic signed [POS_W-1:0]   w_base;
    logic signed [POS_W-1:0]   w_step;
    logic signed [POS_W-1:0]   w_pos;
    logic                      w_wrap_up;
    logic signed [TP_W-1:0]    w_tprod_sh;
    logic signed [SB-1:0]      w_new_held;
    logic        [FB-1:0]      w_frac;
    logic signed [MP_W-1:0]    w_mp_sh;
    logic signed [VAL_W-1:0]   w_val;
    logic signed [VAL_W-1:0]   w_hi;
    logic signed [VAL_W-1:0]   w_lo;

    // Rate magnitude, clamp below the sample rate, divider trial subtract
    always_comb begin
        w_sr_eff    = (r_sample_rate == '0) ? SR_W'(1) : r_sample_rate;
        w_limit     = {w_sr_eff, {RATE_FRAC_BITS{1'b0}}} - LIMIT_W'(1);
        w_rate_mag  = i_rate_hz[RATE_W-1] ? (MAG_W'(~i_rate_hz) + MAG_W'(1))
                                          : MAG_W'(i_rate_hz);
        w_mag_clamp = (LIMIT_W'(r_mag) > w_limit) ? w_limit[MAG_W-1:0] : r_mag;
        w_trial     = {r_rem, r_dsh[PB-1]};
        w_trial_ge  = (w_trial >= {1'b0, w_sr_eff});
        w_trial_sub = w_trial - {1'b0, w_sr_eff};
    end

    // Phase advance; the first sample starts from a phase of exactly one
    always_comb begin
        w_base    = r_first ? {2'b01, {PB{1'b0}}} : {2'b00, r_phase};
        w_step    = {2'b00, r_quo};
        w_pos     = r_neg ? (w_base - w_step) : (w_base + w_step);
        w_wrap_up = !w_pos[PB+1] && w_pos[PB];
    end

    // New target: min + floor(range * draw / 2^16)
    always_comb begin
        w_tprod_sh = r_tprod >>> DRAW_W;
        w_new_held = r_mn + w_tprod_sh[SB-1:0];
    end

    // Interpolated output, saturated
    always_comb begin
        w_frac  = r_phase[PB-1 -: FB];
        w_mp_sh = r_mprod >>> FB;
        w_val   = VAL_W'(r_prev) + $signed(w_mp_sh[VAL_W-1:0]);
        w_hi    = VAL_W'($signed({1'b0, {(SB-1){1'b1}}}));
        w_lo    = VAL_W'($signed({1'b1, {(SB-1){1'b0}}}));
        if (w_val > w_hi) begin
            o_sample = w_hi[SB-1:0];
        end else if (w_val < w_lo) begin
            o_sample = w_lo[SB-1:0];
        end else begin
            o_sample = w_val[SB-1:0];
        end
    end

    assign o_new_target      = r_wrap_up;
    assign o_status.div_more = (r_cnt != CNT_W'(1));
    assign o_status.wrap_up  = r_wrap_up;

    // Register updates per micro-op and configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= SR_RESET;
            r_start_level <= '0;
            r_held        <= '0;
            r_prev        <= '0;
            r_diff        <= '0;
            r_phase       <= '0;
            r_first       <= 1'b1;
            r_wrap_up     <= 1'b0;
            r_cnt         <= '0;
        end else begin
            if (i_cfg.rate_we) begin
                r_sample_rate <= i_cfg.data[SR_W-1:0];
            end
            if (i_cfg.start_we) begin
                r_start_level <= i_cfg.data[SB-1:0];
                // before the first sample the targets follow the start level
                if (r_first) begin
                    r_held <= i_cfg.data[SB-1:0];
                    r_prev <= i_cfg.data[SB-1:0];
                end
            end

            case (i_op)
                OP_LOAD: begin
                    r_mn    <= i_min_level;
                    r_range <= (SB+1)'(i_max_level) - (SB+1)'(i_min_level);
                    r_draw  <= i_random_draw;
                    r_neg   <= i_rate_hz[RATE_W-1];
                    r_mag   <= w_rate_mag;
                end
                OP_CLAMP: begin
                    // high bits start the remainder, low bits shift in
                    r_rem <= SR_W'(w_mag_clamp[MAG_W-1:RATE_FRAC_BITS]);
                    r_dsh <= {w_mag_clamp[RATE_FRAC_BITS-1:0],
                              {(PB-RATE_FRAC_BITS){1'b0}}};
                    r_cnt <= CNT_W'(PB);
                end
                OP_DIV: begin
                    r_rem <= w_trial_ge ? w_trial_sub[SR_W-1:0] : w_trial[SR_W-1:0];
                    r_quo <= {r_quo[PB-2:0], w_trial_ge};
                    r_dsh <= r_dsh << 1;
                    r_cnt <= r_cnt - CNT_W'(1);
                end
                OP_PHASE: begin
                    r_phase   <= w_pos[PB-1:0];
                    r_first   <= 1'b0;
                    r_wrap_up <= w_wrap_up;
                    r_tprod   <= r_range * $signed({1'b0, r_draw});
                end
                OP_TARGET: begin
                    r_prev <= r_held;
                    r_held <= w_new_held;
                end
                OP_DIFF: begin
                    r_diff <= (SB+1)'(r_held) - (SB+1)'(r_prev);
                end
                OP_MUL: begin
                    r_mprod <= r_diff * $signed({1'b0, w_frac});
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/interpolated_random_generator_top.sv
// Top level: interpolated random level generator with microcoded control.
//
//  Channel    Dir  Beat contents                                      Handshake
//  i_sample   in   min_level, max_level, rate_hz, random_draw        valid/ready
//  o_result   out  output_sample, new_target                         valid/ready
//  i_cfg      in   index (0 sample_rate, 1 start_level), data        valid/ready
//
//  Each accepted beat steps through load, clamp, the divider, phase, check,
//  target (only when a new target is picked), diff, multiply and emit; the
//  restoring divider forms the phase step one quotient bit per cycle.
//  Reset is synchronous and active low; no clearing pass is needed.
//  A finished result waits in the output register while the next sample is
//  taken; the sequencer holds on its last step if that register is still full.
//  The configuration channel is always ready.
`default_nettype none

module interpolated_random_generator_top #(
    parameter int SAMPLE_BITS = irg_pkg::SAMPLE_BITS_DEF,
    parameter int PHASE_BITS  = irg_pkg::PHASE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    irg_sample_if.sink    i_sample,
    irg_result_if.source  o_result,
    irg_cfg_if.sink       i_cfg
);
    import irg_pkg::*;

    t_ctl       w_ctl;
    t_flags     w_flags;
    t_dp_status w_status;
    t_cfg_wr    w_cfg;

    logic signed [SAMPLE_BITS-1:0] w_sample;
    logic                          w_new_target;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                          r_out_new;

    // Configuration decode
    assign i_cfg.ready    = 1'b1;
    assign w_cfg.rate_we  = i_cfg.valid && (i_cfg.index == CFG_SAMPLE_RATE);
    assign w_cfg.start_we = i_cfg.valid && (i_cfg.index == CFG_START_LEVEL);
    assign w_cfg.data     = i_cfg.data;

    // Sequencer status
    assign w_flags.in_valid = i_sample.valid;
    assign w_flags.div_more = w_status.div_more;
    assign w_flags.wrap_up  = w_status.wrap_up;
    assign w_flags.out_busy = r_out_valid && !o_result.ready;

    assign i_sample.ready = w_ctl.in_ready;

    irg_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctl   (w_ctl)
    );

    irg_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .PHASE_BITS  (PHASE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (w_ctl.op),
        .i_cfg         (w_cfg),
        .i_min_level   (i_sample.min_level),
        .i_max_level   (i_sample.max_level),
        .i_rate_hz     (i_sample.rate_hz),
        .i_random_draw (i_sample.random_draw),
        .o_status      (w_status),
        .o_sample      (w_sample),
        .o_new_target  (w_new_target)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.op == OP_EMIT) begin
            r_out_sample <= w_sample;
            r_out_new    <= w_new_target;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.output_sample = r_out_sample;
    assign o_result.new_target    = r_out_new;

    // An accepted beat starts the clamp step next
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready) |=> (w_ctl.op == OP_CLAMP))
        else $error("accepted sample did not start the sequence");

    // Never overwrite a result that is still waiting
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.op == OP_EMIT) |-> (!r_out_valid || o_result.ready))
        else $error("result register overwritten");

    // An emitted result shows up as valid
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.op == OP_EMIT) |=> r_out_valid)
        else $error("emitted result not presented");

    // No new sample is taken while the divider runs
    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.op == OP_DIV) |-> !i_sample.ready)
        else $error("input ready during division");

endmodule

`default_nettype wire

FILE: sim/tb_interpolated_random_generator_top.sv
// Testbench: drives sample beats with a self-checking interpolated random level predictor.
`timescale 1ns / 1ps

module tb_interpolated_random_generator_top;
    import irg_pkg::*;

    localparam int SB = SAMPLE_BITS_DEF;
    localparam int PB = PHASE_BITS_DEF;
    localparam int CLK_PERIOD = 20;
    localparam longint TIMEOUT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 2 * (PB + 8);

    localparam longint PHASE_ONE = 64'sd1 << PB;
    localparam longint LEVEL_HI = (64'sd1 <<< (SB - 1)) - 1;
    localparam longint LEVEL_LO = -LEVEL_HI - 1;

    localparam logic signed [SB-1:0] LVL_MAX = {1'b0, {(SB - 1){1'b1}}};
    localparam logic signed [SB-1:0] LVL_MIN = {1'b1, {(SB - 1){1'b0}}};
    localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W - 1){1'b1}}};
    localparam logic signed [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W - 1){1'b0}}};
    localparam logic [DRAW_W-1:0] DRAW_MAX = '1;

    // Register indexes that the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // Rate that moves the phase by exactly one half per sample at 44.1 kHz
    localparam int DIRECTED_SR = 44100;
    localparam logic signed [RATE_W-1:0] RATE_HALF = RATE_W'(DIRECTED_SR * 128);

    typedef struct {
        logic signed [SB-1:0]     min_level;
        logic signed [SB-1:0]     max_level;
        logic signed [RATE_W-1:0] rate_hz;
        logic [DRAW_W-1:0]        random_draw;
        bit                       wait_drain;
    } t_sample_beat;

    typedef struct {
        logic signed [SB-1:0] output_sample;
        logic                 new_target;
    } t_level;

    logic i_clk;
    logic i_rst_n;

    irg_sample_if smp_if ();
    irg_result_if res_if ();
    irg_cfg_if    cfg_if ();

    interpolated_random_generator_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp_if),
        .o_result (res_if),
        .i_cfg    (cfg_if)
    );

    // Pending beats, expected results, idle shaping
    t_sample_beat pending_samples[$];
    t_level       expected_levels[$];
    t_sample_beat next_beat;
    t_level       want;
    bit           sample_taken;
    int           send_idle_pct;
    int           ready_idle_pct;
    int           err_count;

    // Predictor copy of registers and generator state
    logic [SR_W-1:0]      rate_reg;
    logic signed [SB-1:0] start_reg;
    longint               held_lvl;
    longint               prev_lvl;
    longint               lvl_delta;
    longint               phase_acc;
    bit                   first_beat;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Advance the phase by one sample and work out the resulting level
    function automatic t_level advance_lfo(input logic signed [SB-1:0] lo,
                                           input logic signed [SB-1:0] hi,
                                           input logic signed [RATE_W-1:0] rate,
                                           input logic [DRAW_W-1:0] draw);
        longint sr, lim, mag, step, pos, span, val;
        t_level res;
        sr = (rate_reg == 0) ? 64'sd1 : longint'(rate_reg);
        lim = sr * 256 - 1;
        mag = (rate < 0) ? -longint'(rate) : longint'(rate);
        if (mag > lim) mag = lim;
        step = (mag << (PB - RATE_FRAC_BITS)) / sr;

        // first sample treats the phase as exactly one
        pos = first_beat ? PHASE_ONE : phase_acc;
        first_beat = 1'b0;
        pos = (rate < 0) ? pos - step : pos + step;

        res.new_target = 1'b0;
        if (pos < 0) begin
            pos = pos + PHASE_ONE;
        end else if (pos >= PHASE_ONE) begin
            pos = pos - PHASE_ONE;
            span = longint'(hi) - longint'(lo);
            prev_lvl = held_lvl;
            held_lvl = longint'(lo) + ((span * longint'(draw)) >>> DRAW_W);
            lvl_delta = held_lvl - prev_lvl;
            res.new_target = 1'b1;
        end
        phase_acc = pos;

        val = prev_lvl + ((lvl_delta * phase_acc) >>> PB);
        if (val > LEVEL_HI) val = LEVEL_HI;
        if (val < LEVEL_LO) val = LEVEL_LO;
        res.output_sample = val[SB-1:0];
        return res;
    endfunction

    function automatic logic signed [SB-1:0] pick_level();
        logic signed [SB-1:0] lvl;
        case ($urandom_range(0, 6))
            0: lvl = LVL_MIN;
            1: lvl = LVL_MAX;
            2: lvl = SB'($urandom) + SB'($urandom_range(0, 2047)) - SB'(1024);
            default: lvl = SB'($urandom);
        endcase
        return lvl;
    endfunction

    function automatic logic signed [RATE_W-1:0] pick_rate();
        logic signed [RATE_W-1:0] r;
        longint near;
        case ($urandom_range(0, 9))
            0, 1, 2: r = RATE_W'($urandom);
            3, 4, 5: r = RATE_W'($urandom_range(0, 4095));
            6, 7:    r = RATE_W'($urandom_range(0, 1 << 20));
            8: begin
                case ($urandom_range(0, 2))
                    0: r = RATE_MAX;
                    1: r = RATE_MIN;
                    default: r = '0;
                endcase
            end
            default: begin
                // around the clamp point of the current sample rate
                near = longint'(rate_reg) * 256 + longint'(int'($urandom_range(0, 4))) - 2;
                if (near > longint'(RATE_MAX)) near = longint'(RATE_MAX);
                r = near[RATE_W-1:0];
            end
        endcase
        if ($urandom_range(0, 1) == 1) r = -r;
        return r;
    endfunction

    task automatic push_beat(input logic signed [SB-1:0] lo, input logic signed [SB-1:0] hi,
                             input logic signed [RATE_W-1:0] rate,
                             input logic [DRAW_W-1:0] draw, input bit drain);
        t_sample_beat b;
        b.min_level   = lo;
        b.max_level   = hi;
        b.rate_hz     = rate;
        b.random_draw = draw;
        b.wait_drain  = drain;
        pending_samples.push_back(b);
    endtask

    // Runs of beats share bounds and rate, as an LFO would see them; draws vary
    task automatic queue_random_samples(input int count);
        int n, k, run_len;
        logic signed [SB-1:0] lo, hi;
        logic signed [RATE_W-1:0] rate;
        logic [DRAW_W-1:0] draw;
        n = 0;
        while (n < count) begin
            run_len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 16);
            lo = pick_level();
            hi = pick_level();
            rate = pick_rate();
            for (k = 0; k < run_len && n < count; k++) begin
                case ($urandom_range(0, 9))
                    0: draw = '0;
                    1: draw = DRAW_MAX;
                    default: draw = DRAW_W'($urandom);
                endcase
                push_beat(lo, hi, rate, draw, n == count / 2);
                n++;
            end
        end
    endtask

    // One config beat; valid stays up for back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx == CFG_SAMPLE_RATE) begin
            rate_reg = value[SR_W-1:0];
        end else if (idx == CFG_START_LEVEL) begin
            start_reg = value[SB-1:0];
            if (first_beat) begin
                held_lvl = longint'(start_reg);
                prev_lvl = longint'(start_reg);
            end
        end
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Upper data bits carry noise that the block must ignore
    task automatic write_rate(input logic [SR_W-1:0] sr);
        write_reg(CFG_SAMPLE_RATE, {(CFG_DATA_W - SR_W)'($urandom), sr});
    endtask

    task automatic write_start(input logic signed [SB-1:0] lvl);
        write_reg(CFG_START_LEVEL, {(CFG_DATA_W - SB)'($urandom), lvl});
    endtask

    // Wait for the block to drain, then let its pipeline go quiet
    task automatic settle();
        while (pending_samples.size() != 0 || expected_levels.size() != 0 || smp_if.valid)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_directed_samples();
        logic signed [SB-1:0] same;
        same = SB'($urandom);
        // half-step rate lands exactly on the wrap points
        push_beat(-(LVL_MAX >>> 1), LVL_MAX >>> 1,
                  ($urandom_range(0, 1) == 1) ? RATE_HALF : -RATE_HALF, 16'h8000, 1'b0);
        push_beat(LVL_MIN, LVL_MAX, RATE_HALF, DRAW_MAX, 1'b0);
        push_beat(LVL_MIN, LVL_MAX, RATE_HALF, '0, 1'b0);
        push_beat(LVL_MIN, LVL_MAX, -RATE_HALF, DRAW_MAX, 1'b0);
        push_beat(LVL_MIN, LVL_MAX, -RATE_HALF, DRAW_MAX, 1'b0);
        push_beat(LVL_MIN, LVL_MAX, -RATE_HALF, DRAW_MAX, 1'b0);
        push_beat(LVL_MIN, LVL_MAX, '0, DRAW_MAX, 1'b0);
        // fastest rates both ways, draw extremes
        push_beat(LVL_MIN, LVL_MAX, RATE_MAX, DRAW_MAX, 1'b0);
        push_beat(LVL_MIN, LVL_MAX, RATE_MAX, '0, 1'b0);
        push_beat(LVL_MIN, LVL_MAX, RATE_MAX, 16'd1, 1'b0);
        push_beat(LVL_MIN, LVL_MAX, RATE_MIN, DRAW_MAX, 1'b0);
        push_beat(LVL_MIN, LVL_MAX, RATE_MIN, '0, 1'b0);
        // reversed bounds
        push_beat(LVL_MAX, LVL_MIN, RATE_MAX, DRAW_MAX, 1'b0);
        push_beat(LVL_MAX, LVL_MIN, RATE_MAX, '0, 1'b0);
        push_beat(LVL_MAX, LVL_MIN, RATE_MAX, 16'h8000, 1'b0);
        push_beat(same, same, RATE_MAX, DRAW_W'($urandom), 1'b0);
        // slowest rates, then equal bounds at a mid rate
        push_beat(LVL_MIN, LVL_MAX, RATE_W'(1), DRAW_MAX, 1'b0);
        push_beat(LVL_MIN, LVL_MAX, -RATE_W'(1), DRAW_MAX, 1'b0);
        push_beat(LVL_MIN, LVL_MIN, RATE_W'(24'h400000), DRAW_MAX, 1'b0);
        // hold the sender until the block is empty
        push_beat(pick_level(), pick_level(), pick_rate(), DRAW_W'($urandom), 1'b1);
    endtask

    // Sample channel driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            smp_if.valid <= 1'b0;
        end else if (!smp_if.valid || sample_taken) begin
            sample_taken = 1'b0;
            if (pending_samples.size() != 0
                && !(pending_samples[0].wait_drain && expected_levels.size() != 0)
                && $urandom_range(0, 99) >= send_idle_pct) begin
                next_beat = pending_samples.pop_front();
                smp_if.min_level   <= next_beat.min_level;
                smp_if.max_level   <= next_beat.max_level;
                smp_if.rate_hz     <= next_beat.rate_hz;
                smp_if.random_draw <= next_beat.random_draw;
                smp_if.valid       <= 1'b1;
            end else begin
                smp_if.valid <= 1'b0;
            end
        end
    end

    // Accepted sample beat: predict its result
    always @(posedge i_clk) begin
        if (i_rst_n && smp_if.valid && smp_if.ready) begin
            expected_levels.push_back(advance_lfo(smp_if.min_level, smp_if.max_level,
                                                  smp_if.rate_hz, smp_if.random_draw));
            sample_taken = 1'b1;
        end
    end

    // Result back-pressure
    always @(negedge i_clk) begin
        res_if.ready <= i_rst_n && ($urandom_range(0, 99) >= ready_idle_pct);
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_levels.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result, expected none, got sample %0d new_target %0b",
                         $time, res_if.output_sample, res_if.new_target);
            end else begin
                want = expected_levels.pop_front();
                if (res_if.output_sample !== want.output_sample) begin
                    err_count++;
                    $display("%0t: output_sample mismatch, expected %0d, got %0d",
                             $time, want.output_sample, res_if.output_sample);
                end
                if (res_if.new_target !== want.new_target) begin
                    err_count++;
                    $display("%0t: new_target mismatch, expected %0b, got %0b",
                             $time, want.new_target, res_if.new_target);
                end
            end
        end
    end

    // Main sequence
    initial begin
        smp_if.valid       = 1'b0;
        smp_if.min_level   = '0;
        smp_if.max_level   = '0;
        smp_if.rate_hz     = '0;
        smp_if.random_draw = '0;
        res_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = '0;
        cfg_if.data        = '0;
        i_rst_n            = 1'b0;
        sample_taken       = 1'b0;
        err_count          = 0;
        rate_reg           = SR_RESET;
        start_reg          = '0;
        held_lvl           = 0;
        prev_lvl           = 0;
        lvl_delta          = 0;
        phase_acc          = 0;
        first_beat         = 1'b1;
        send_idle_pct      = 15;
        ready_idle_pct     = 53;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // start level written while the first sample is still pending
        write_rate(SR_W'(DIRECTED_SR));
        write_start(SB'($urandom));
        write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
        end_writes();
        queue_directed_samples();

        // zero sample rate behaves as 1 Hz; start level no longer loads state
        settle();
        write_rate('0);
        write_start(LVL_MAX);
        end_writes();
        queue_random_samples(60);

        settle();
        write_rate(SR_W'(1));
        write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));
        end_writes();
        queue_random_samples(80);

        settle();
        send_idle_pct  = 53;
        ready_idle_pct = 15;
        write_rate(SR_W'(192000));
        end_writes();
        queue_random_samples(100);

        settle();
        write_rate('1);
        write_start(LVL_MIN);
        end_writes();
        queue_random_samples(60);

        // low sample rates make the clamp bite often
        settle();
        write_rate(SR_W'($urandom_range(2, 4000)));
        end_writes();
        queue_random_samples(100);

        settle();
        send_idle_pct  = 0;
        ready_idle_pct = 0;
        write_rate(SR_W'(48000));
        end_writes();
        queue_random_samples(120);

        settle();
        write_rate(SR_W'($urandom_range(1, 192000)));
        write_start(SB'($urandom));
        end_writes();
        queue_random_samples(130);

        settle();
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
